>>> design/i2s_frame_rms_meter_macros.svh
// Assertion macros used by the property checker of the RMS meter.
`ifndef I2S_FRAME_RMS_METER_MACROS_SVH
`define I2S_FRAME_RMS_METER_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define IFRM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ifrm property violated");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define IFRM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ifrm property violated");

`endif

>>> design/ifrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ifrm_pkg;

   // Fixed widths of the I2S word, the sample and the arithmetic around them.
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned SAMPLE_W   = 24;
   localparam int unsigned SQUARE_W   = 2 * SAMPLE_W;
   localparam int unsigned MEAN_W     = 48;
   localparam int unsigned RMS_W      = 24;
   localparam int unsigned SQRT_STEPS = MEAN_W / 2;
   localparam int unsigned SREM_W     = RMS_W + 2;
   localparam int unsigned SQRT_W     = SREM_W + 2;

   // Largest possible level: the root of the square of the most negative sample.
   localparam logic [RMS_W-1:0] RMS_MAX = 24'h800000;

   typedef struct packed {
      logic [WORD_W-1:0] raw_word;
      logic              frame_end;
   } req_type;

   typedef struct packed {
      logic [RMS_W-1:0] rms_level;
      logic             overrun;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_DIV,
      ST_SQRT,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

>>> design/i2s_frame_rms_meter.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Payload            Handshake
// req      in         ifrm_pkg::req_type req_valid / req_ready
// rsp      out        ifrm_pkg::rsp_type rsp_valid / rsp_ready
//
// A sample that does not end a frame is transferred, squared and accumulated.
// A frame end adds restoring division of the SUM_W-bit sum (one quotient bit a cycle),
// square root (one root bit a cycle) and a final step that loads the result.
// Both share one compare-subtract unit.
// Synchronous reset clears the sum, the count, the overrun flag and the result valid.
// A stalled result sits in the output register; a new frame may start meanwhile and
// only waits in the final step if the previous result has not been taken.
module i2s_frame_rms_meter #(
   parameter int unsigned FRAME_SAMPLES = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ifrm_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ifrm_pkg::rsp_type      rsp_payload
);

   localparam int unsigned CNT_W  = $clog2(FRAME_SAMPLES + 1);
   localparam int unsigned SUM_W  = ifrm_pkg::SQUARE_W - 2 + CNT_W;
   localparam int unsigned STEP_W = $clog2(SUM_W);
   localparam int unsigned UNIT_W =
      (CNT_W + 1 > ifrm_pkg::SQRT_W) ? CNT_W + 1 : ifrm_pkg::SQRT_W;

   ifrm_pkg::state_type state_ff, state_in;

   logic [ifrm_pkg::SAMPLE_W-1:0] mag_ff, mag_in;
   logic                          end_ff, end_in;
   logic [ifrm_pkg::SQUARE_W-1:0] sq_ff, sq_in;
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic                          ovf_ff, ovf_in;
   logic [SUM_W-1:0]              quo_ff, quo_in;
   logic [CNT_W-1:0]              dvs_ff, dvs_in;
   logic [CNT_W-1:0]              rem_ff, rem_in;
   logic [ifrm_pkg::MEAN_W-1:0]   rad_ff, rad_in;
   logic [ifrm_pkg::SREM_W-1:0]   srem_ff, srem_in;
   logic [ifrm_pkg::RMS_W-1:0]    root_ff, root_in;
   logic                          ovf_res_ff, ovf_res_in;
   logic [STEP_W-1:0]             step_ff, step_in;
   ifrm_pkg::rsp_type             rsp_ff, rsp_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic [ifrm_pkg::SAMPLE_W-1:0] sample;
   logic [ifrm_pkg::SAMPLE_W-1:0] mag;
   logic [SUM_W-1:0]              sum_new;
   logic [CNT_W-1:0]              cnt_new;
   logic                          ovf_new;
   logic                          rsp_load;

   logic [CNT_W:0]                div_a;
   logic [ifrm_pkg::SQRT_W-1:0]   sqrt_a;
   logic [ifrm_pkg::SREM_W-1:0]   sqrt_b;
   logic [UNIT_W-1:0]             unit_a;
   logic [UNIT_W-1:0]             unit_b;
   logic [UNIT_W-1:0]             unit_diff;
   logic                          unit_ge;

   // Magnitude of the signed sample in the upper bits of the I2S word.
   assign sample = req_payload.raw_word[ifrm_pkg::WORD_W-1 -: ifrm_pkg::SAMPLE_W];
   assign mag    = sample[ifrm_pkg::SAMPLE_W-1] ?
                   (~sample + ifrm_pkg::SAMPLE_W'(1)) : sample;

   // Operands of the shared unit: one divider step or one square-root step.
   assign div_a  = {rem_ff, quo_ff[SUM_W-1]};
   assign sqrt_a = {srem_ff, rad_ff[ifrm_pkg::MEAN_W-1 -: 2]};
   assign sqrt_b = {root_ff, 2'b01};
   assign unit_a = (state_ff == ifrm_pkg::ST_SQRT) ? UNIT_W'(sqrt_a) : UNIT_W'(div_a);
   assign unit_b = (state_ff == ifrm_pkg::ST_SQRT) ? UNIT_W'(sqrt_b) : UNIT_W'(dvs_ff);

   ifrm_cmpsub #(
      .W (UNIT_W)
   ) u_cmpsub (
      .a    (unit_a),
      .b    (unit_b),
      .diff (unit_diff),
      .ge   (unit_ge)
   );

   // Accumulation of one sample, or the overrun flag once the frame is full.
   always_comb begin
      sum_new = sum_ff;
      cnt_new = cnt_ff;
      ovf_new = ovf_ff;
      if (cnt_ff < CNT_W'(FRAME_SAMPLES)) begin
         sum_new = sum_ff + SUM_W'(sq_ff);
         cnt_new = cnt_ff + CNT_W'(1);
      end else begin
         ovf_new = 1'b1;
      end
   end

   // Sequencer: next state and next values of all registers.
   always_comb begin
      state_in   = state_ff;
      mag_in     = mag_ff;
      end_in     = end_ff;
      sq_in      = sq_ff;
      sum_in     = sum_ff;
      cnt_in     = cnt_ff;
      ovf_in     = ovf_ff;
      quo_in     = quo_ff;
      dvs_in     = dvs_ff;
      rem_in     = rem_ff;
      rad_in     = rad_ff;
      srem_in    = srem_ff;
      root_in    = root_ff;
      ovf_res_in = ovf_res_ff;
      step_in    = step_ff;
      rsp_load   = 1'b0;

      case (state_ff)
         ifrm_pkg::ST_IDLE: begin
            if (req_valid) begin
               mag_in   = mag;
               end_in   = req_payload.frame_end;
               state_in = ifrm_pkg::ST_MUL;
            end
         end

         ifrm_pkg::ST_MUL: begin
            sq_in    = ifrm_pkg::SQUARE_W'(mag_ff) * ifrm_pkg::SQUARE_W'(mag_ff);
            state_in = ifrm_pkg::ST_ADD;
         end

         ifrm_pkg::ST_ADD: begin
            if (end_ff) begin
               // Hand the totals to the divider and start a fresh frame.
               quo_in     = sum_new;
               dvs_in     = (cnt_new == '0) ? CNT_W'(1) : cnt_new;
               rem_in     = '0;
               ovf_res_in = ovf_new;
               sum_in     = '0;
               cnt_in     = '0;
               ovf_in     = 1'b0;
               step_in    = STEP_W'(SUM_W - 1);
               state_in   = ifrm_pkg::ST_DIV;
            end else begin
               sum_in   = sum_new;
               cnt_in   = cnt_new;
               ovf_in   = ovf_new;
               state_in = ifrm_pkg::ST_IDLE;
            end
         end

         ifrm_pkg::ST_DIV: begin
            // Restoring division: dividend bits shift out as quotient bits shift in.
            quo_in = {quo_ff[SUM_W-2:0], unit_ge};
            rem_in = unit_ge ? unit_diff[CNT_W-1:0] : div_a[CNT_W-1:0];
            if (step_ff == '0) begin
               rad_in   = ifrm_pkg::MEAN_W'(quo_in);
               srem_in  = '0;
               root_in  = '0;
               step_in  = STEP_W'(ifrm_pkg::SQRT_STEPS - 1);
               state_in = ifrm_pkg::ST_SQRT;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end

         ifrm_pkg::ST_SQRT: begin
            // Digit-by-digit root: two radicand bits in, one root bit out.
            rad_in = {rad_ff[ifrm_pkg::MEAN_W-3:0], 2'b00};
            if (unit_ge) begin
               srem_in = unit_diff[ifrm_pkg::SREM_W-1:0];
               root_in = {root_ff[ifrm_pkg::RMS_W-2:0], 1'b1};
            end else begin
               srem_in = sqrt_a[ifrm_pkg::SREM_W-1:0];
               root_in = {root_ff[ifrm_pkg::RMS_W-2:0], 1'b0};
            end
            if (step_ff == '0) begin
               state_in = ifrm_pkg::ST_DONE;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end

         ifrm_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ifrm_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ifrm_pkg::ST_IDLE;
         end
      endcase
   end

   // Output register: loads a finished result, clears after its transfer.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_in.rms_level = root_ff;
         rsp_in.overrun   = ovf_res_ff;
         rsp_valid_in     = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state and frame totals.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ifrm_pkg::ST_IDLE;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      end_ff     <= end_in;
      sq_ff      <= sq_in;
      quo_ff     <= quo_in;
      dvs_ff     <= dvs_in;
      rem_ff     <= rem_in;
      rad_ff     <= rad_in;
      srem_ff    <= srem_in;
      root_ff    <= root_in;
      ovf_res_ff <= ovf_res_in;
      step_ff    <= step_in;
      rsp_ff     <= rsp_in;
   end

   assign req_ready   = (state_ff == ifrm_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

>>> design/ifrm_cmpsub.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared compare-and-subtract unit. The borrow of a single subtractor gives the
// compare, so the divider and the square root both get a >= b and a - b from it.
module ifrm_cmpsub #(
   parameter int unsigned W = 28
) (
   input  wire logic [W-1:0] a,
   input  wire logic [W-1:0] b,
   output logic      [W-1:0] diff,
   output logic              ge
);

   logic [W:0] wide_diff;

   assign wide_diff = {1'b0, a} - {1'b0, b};
   assign diff      = wide_diff[W-1:0];
   assign ge        = ~wide_diff[W];

endmodule

`default_nettype wire

>>> design/ifrm_props.sv
`timescale 1ns / 1ps
`default_nettype none

`include "i2s_frame_rms_meter_macros.svh"

// Properties of the meter as seen on its ports.
module ifrm_props (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire ifrm_pkg::rsp_type rsp_payload
);

   // A result that is not taken stays offered and unchanged.
   `IFRM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // No level exceeds the root of the largest possible square.
   `IFRM_ASSERT_IMP(a_rms_range, clock, reset, rsp_valid, rsp_payload.rms_level <= ifrm_pkg::RMS_MAX)

   // Each sample keeps the block busy for at least the following cycle.
   `IFRM_ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_valid && req_ready, !req_ready)

   // A new result appears only as the sequencer returns to idle.
   `IFRM_ASSERT_IMP(a_result_at_idle, clock, reset, $rose(rsp_valid), req_ready)

endmodule

bind i2s_frame_rms_meter ifrm_props u_props (.*);

`default_nettype wire

>>> dv/i2s_frame_rms_meter_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// Watches both channels of the RMS meter, predicts each frame's level from the
// accepted samples and compares every result transfer with the oldest prediction.
module i2s_frame_rms_meter_checker #(
   parameter int unsigned FRAME_SAMPLES = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire ifrm_pkg::req_type req_payload,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire ifrm_pkg::rsp_type rsp_payload,
   output int                     fail_count,
   output int                     levels_pending
);

   localparam int unsigned COUNT_W = $clog2(FRAME_SAMPLES + 1);

   // Running frame state, mirroring what the block accumulates.
   logic [63:0]        energy_sum;
   logic [COUNT_W-1:0] sample_total;
   logic               clipped;
   ifrm_pkg::rsp_type  level_queue[$];

   // Integer square root, one result bit at a time from the top.
   function automatic logic [ifrm_pkg::RMS_W-1:0] int_root(input logic [63:0] value);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= value) begin
            root = trial;
         end
      end
      return root[ifrm_pkg::RMS_W-1:0];
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] level check: %s", $time, msg);
      fail_count++;
   endtask

   // Fold one accepted sample into the frame; a frame end queues the level.
   task automatic take_sample(input ifrm_pkg::req_type item);
      logic [ifrm_pkg::SAMPLE_W-1:0] bits;
      logic [ifrm_pkg::SAMPLE_W-1:0] mag;
      logic [ifrm_pkg::SQUARE_W-1:0] square;
      logic [63:0]                   divisor;
      ifrm_pkg::rsp_type             level;
      bits = item.raw_word[ifrm_pkg::WORD_W-1:ifrm_pkg::WORD_W-ifrm_pkg::SAMPLE_W];
      mag = bits[ifrm_pkg::SAMPLE_W-1] ? (~bits + 1'b1) : bits;
      square = {{ifrm_pkg::SAMPLE_W{1'b0}}, mag} * {{ifrm_pkg::SAMPLE_W{1'b0}}, mag};
      if (sample_total < FRAME_SAMPLES) begin
         energy_sum = energy_sum + 64'(square);
         sample_total = sample_total + 1'b1;
      end else begin
         clipped = 1'b1;
      end
      if (item.frame_end) begin
         divisor = (sample_total != 0) ? 64'(sample_total) : 64'd1;
         level.rms_level = int_root(energy_sum / divisor);
         level.overrun = clipped;
         level_queue.push_back(level);
         energy_sum = '0;
         sample_total = '0;
         clipped = 1'b0;
      end
   endtask

   // Compare one result transfer, field by field, with the oldest prediction.
   task automatic check_level(input ifrm_pkg::rsp_type got);
      ifrm_pkg::rsp_type want;
      if (level_queue.size() == 0) begin
         report_mismatch($sformatf("result with nothing pending: level %0d overrun %0b",
                                   got.rms_level, got.overrun));
         return;
      end
      want = level_queue.pop_front();
      if (got.rms_level !== want.rms_level) begin
         report_mismatch($sformatf("rms_level %0d, predicted %0d",
                                   got.rms_level, want.rms_level));
      end
      if (got.overrun !== want.overrun) begin
         report_mismatch($sformatf("overrun %0b, predicted %0b", got.overrun, want.overrun));
      end
   endtask

   // Results are checked before samples so that a frame end and the previous
   // frame's result in the same cycle are handled in order.
   always @(posedge clock) begin
      if (reset) begin
         energy_sum = '0;
         sample_total = '0;
         clipped = 1'b0;
         level_queue.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_level(rsp_payload);
         end
         if (req_valid && req_ready) begin
            take_sample(req_payload);
         end
      end
      levels_pending <= level_queue.size();
   end

endmodule

`default_nettype wire

>>> dv/tb_i2s_frame_rms_meter.sv
`timescale 1ns / 1ps
`default_nettype none

module tb_i2s_frame_rms_meter;

   typedef enum int unsigned {
      WAVE_FULL,
      WAVE_QUIET,
      WAVE_EDGE,
      WAVE_PEAK
   } wave_type;

   localparam int unsigned FRAME_SAMPLES = 256;
   localparam int unsigned MIN_ITEMS     = 800;
   localparam int unsigned SETTLE_CYCLES = 120;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   ifrm_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   ifrm_pkg::rsp_type rsp_payload;
   int                fail_count;
   int                levels_pending;
   logic              no_idle = 1'b0;
   int unsigned       ready_hold = 0;
   int unsigned       items_sent = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   i2s_frame_rms_meter #(
      .FRAME_SAMPLES(FRAME_SAMPLES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   i2s_frame_rms_meter_checker #(
      .FRAME_SAMPLES(FRAME_SAMPLES)
   ) level_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .fail_count    (fail_count),
      .levels_pending(levels_pending)
   );

   // Idle length: mostly none or short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (no_idle) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
         return 0;
      end
      if (roll < 85) begin
         return $urandom_range(1, 3);
      end
      if (roll < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // One I2S word; the low byte is always random since the block drops it.
   function automatic logic [ifrm_pkg::WORD_W-1:0] pick_word(input wave_type wave);
      logic [ifrm_pkg::SAMPLE_W-1:0] amp;
      int                            quiet;
      case (wave)
         WAVE_FULL: begin
            amp = ifrm_pkg::SAMPLE_W'($urandom);
         end
         WAVE_QUIET: begin
            quiet = int'($urandom_range(0, 8191)) - 4096;
            amp = ifrm_pkg::SAMPLE_W'(quiet);
         end
         WAVE_EDGE: begin
            case ($urandom_range(0, 4))
               0: amp = 24'h800000;
               1: amp = 24'h7FFFFF;
               2: amp = 24'h000000;
               3: amp = 24'hFFFFFF;
               default: amp = 24'h000001;
            endcase
         end
         default: begin
            amp = 24'h800000;
         end
      endcase
      return {amp, 8'($urandom)};
   endfunction

   // Present one word and hold it until the transfer; ready is sampled at the
   // falling edge, where it is stable for the next rising edge.
   task automatic send_word(input logic [ifrm_pkg::WORD_W-1:0] word, input logic last);
      int unsigned gap;
      logic        taken;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{raw_word: word, frame_end: last};
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      items_sent++;
   endtask

   task automatic send_frame(input int unsigned length, input wave_type wave);
      for (int unsigned k = 1; k <= length; k++) begin
         send_word(pick_word(wave), k == length);
      end
   endtask

   // Result side: stretches of ready and of stall, each of random length.
   always @(posedge clock) begin
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (no_idle) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 2) != 0);
         ready_hold <= pick_gap();
      end
   end

   initial begin
      int unsigned round_no;
      int unsigned length;
      int unsigned roll;
      wave_type    wave;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Single-sample frames at the extremes of the sample, low byte ignored.
      send_word(32'h8000_0000, 1'b1);
      send_word(32'h7FFF_FF00, 1'b1);
      send_word(32'hFFFF_FF00, 1'b1);
      send_word(32'h0000_00FF, 1'b1);
      send_word(32'h0000_0100, 1'b1);
      send_word(32'hFFFF_FFFF, 1'b1);
      send_word(32'h7FFF_FFFF, 1'b1);

      // Short frames: full negative scale, mixed extremes, opposite signs and a
      // mean that the division has to floor.
      repeat (3) send_word(32'h8000_0000, 1'b0);
      send_word(32'h8000_0000, 1'b1);
      send_word(32'h7FFF_FF00, 1'b0);
      send_word(32'h8000_0000, 1'b0);
      send_word(32'h0000_0000, 1'b1);
      send_word(32'h0000_0300, 1'b0);
      send_word(32'hFFFF_FD00, 1'b1);
      send_word(32'h0000_0100, 1'b0);
      send_word(32'h0000_0200, 1'b1);

      // Random frames: mostly short ones, a full-capacity frame at full scale,
      // a frame past capacity and now and then another long frame.
      round_no = 0;
      while (items_sent < MIN_ITEMS) begin
         no_idle = ($urandom_range(0, 7) == 0);
         roll = $urandom_range(0, 9);
         if (roll < 4) begin
            wave = WAVE_FULL;
         end else if (roll < 7) begin
            wave = WAVE_QUIET;
         end else if (roll < 9) begin
            wave = WAVE_EDGE;
         end else begin
            wave = WAVE_PEAK;
         end
         if (round_no == 2) begin
            length = FRAME_SAMPLES;
            wave = WAVE_PEAK;
         end else if (round_no == 5) begin
            length = $urandom_range(FRAME_SAMPLES + 1, FRAME_SAMPLES + 40);
         end else if ($urandom_range(0, 19) == 0) begin
            length = $urandom_range(FRAME_SAMPLES - 60, FRAME_SAMPLES + 40);
         end else begin
            length = $urandom_range(1, 12);
         end
         send_frame(length, wave);
         round_no++;
      end
      req_valid <= 1'b0;
      no_idle = 1'b0;

      // Drain the outstanding levels, then watch for stray results. The first
      // falling edge lets the checker count the last frame end.
      @(negedge clock);
      while (levels_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
